@@ src/jac_pkg.sv @@
// jac_pkg: shared types and constants of the joystick axis conditioner
// used by jac_mul and joystick_axis_conditioner_top; depends on nothing

package jac_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // packed threshold and key tables
  localparam int TBL_N    = 4;
  localparam int TBL_IW   = 2;
  localparam int THR_W    = 16;
  localparam int KEY_W    = 9;

  // register file
  localparam int CFG_DW   = 64;
  localparam int CFG_AW   = 6;

  localparam logic [15:0] PRE_GAIN_RST = 16'd41;
  localparam logic [15:0] GAIN_RST     = 16'd256;
  localparam logic [15:0] DEADZONE_RST = 16'd500;

  typedef enum logic [2:0] {
    REG_PRE_GAIN   = 3'd0,
    REG_GAIN       = 3'd1,
    REG_DEADZONE   = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_ROUTING    = 3'd4,
    REG_BTN_COUNT  = 3'd5,
    REG_THRESHOLDS = 3'd6,
    REG_KEYS       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_POS  = 2'd1,
    MODE_ANG  = 2'd2,
    MODE_BTN  = 2'd3
  } mode_t;

  localparam logic [1:0] EV_POS = 2'd0;
  localparam logic [1:0] EV_ANG = 2'd1;
  localparam logic [1:0] EV_KEY = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_ADJ  = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_RND  = 7'b0010000,
    ST_SCAN = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

endpackage

@@ src/joystick_axis_conditioner_top.sv @@
// joystick_axis_conditioner_top: axis sample conditioning and event generation
// depends on jac_pkg and jac_mul (one multiplier shared by both gain stages)
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    in_axis_sample
//  out      source     out_valid / out_stall  event kind, component, delta, key, flags
//  cfg      apb slave  psel/penable/pwrite    paddr (8-byte stride), pwdata, prdata
//
// a sample passes MUL1, ADJ, MUL2 and RND to the conditioned value: two passes through the
// shared multiplier plus deadzone and rounding steps; event beats then wait on out_stall
// button mode first scans one entry a cycle, plus a closing check when none matches
// in_stall stays high from acceptance until the last event is loaded or no event is due
// the output register holds a beat under out_stall; the next sample may enter meanwhile
// rst_n is synchronous; control and config registers reset and held flags clear

module joystick_axis_conditioner_top
  import jac_pkg::*;
#(
  parameter int BUTTON_SLOTS = 4
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_axis_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_kind,
  output logic [1:0]           out_component,
  output logic signed [31:0]   out_delta,
  output logic [KEY_W-1:0]     out_key_code,
  output logic                 out_key_down,
  output logic                 out_last_event,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int USE_MAX = (BUTTON_SLOTS < TBL_N) ? BUTTON_SLOTS : TBL_N;

  // configuration registers
  logic [15:0]            pre_gain_r;
  logic [15:0]            gain_r;
  logic [15:0]            deadzone_r;
  logic signed [15:0]     offset_r;
  logic [2:0]             routing_r;
  logic [2:0]             btn_count_r;
  logic [TBL_N*THR_W-1:0] thr_r;
  logic [TBL_N*KEY_W-1:0] keys_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r  <= PRE_GAIN_RST;
      gain_r      <= GAIN_RST;
      deadzone_r  <= DEADZONE_RST;
      offset_r    <= '0;
      routing_r   <= '0;
      btn_count_r <= '0;
      thr_r       <= '0;
      keys_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PRE_GAIN:   pre_gain_r  <= pwdata[15:0];
        REG_GAIN:       gain_r      <= pwdata[15:0];
        REG_DEADZONE:   deadzone_r  <= pwdata[15:0];
        REG_OFFSET:     offset_r    <= pwdata[15:0];
        REG_ROUTING:    routing_r   <= pwdata[2:0];
        REG_BTN_COUNT:  btn_count_r <= pwdata[2:0];
        REG_THRESHOLDS: thr_r       <= pwdata[TBL_N*THR_W-1:0];
        REG_KEYS:       keys_r      <= pwdata[TBL_N*KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_PRE_GAIN:   prdata = CFG_DW'(pre_gain_r);
      REG_GAIN:       prdata = CFG_DW'(gain_r);
      REG_DEADZONE:   prdata = CFG_DW'(deadzone_r);
      REG_OFFSET:     prdata = CFG_DW'($unsigned(offset_r));
      REG_ROUTING:    prdata = CFG_DW'(routing_r);
      REG_BTN_COUNT:  prdata = CFG_DW'(btn_count_r);
      REG_THRESHOLDS: prdata = CFG_DW'(thr_r);
      REG_KEYS:       prdata = CFG_DW'(keys_r);
      default:        prdata = '0;
    endcase
  end

  // table views
  logic signed [THR_W-1:0] thr_a  [TBL_N];
  logic [KEY_W-1:0]        keys_a [TBL_N];

  always_comb begin
    for (int i = 0; i < TBL_N; i++) begin
      thr_a[i]  = thr_r[i*THR_W +: THR_W];
      keys_a[i] = keys_r[i*KEY_W +: KEY_W];
    end
  end

  // sequencer and datapath state
  state_t                   state_r, state_nxt;
  logic signed [15:0]       sample_r;
  logic signed [MUL_A_W-1:0] v_r, v_nxt;
  logic signed [31:0]       val_r, val_nxt;
  logic [2:0]               idx_r, idx_nxt;
  logic [BUTTON_SLOTS-1:0]  held_r, held_nxt;
  logic [TBL_N-1:0]         rel_r, rel_nxt;
  logic                     press_pend_r, press_pend_nxt;
  logic [TBL_IW-1:0]        press_idx_r, press_idx_nxt;
  logic                     dlt_pend_r, dlt_pend_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     in_acc;
  logic                     out_free;
  mode_t                    mode;
  logic                     alt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign mode     = mode_t'(routing_r[1:0]);
  assign alt      = routing_r[2];

  // shared multiplier
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = {{(MUL_A_W-16){sample_r[15]}}, sample_r};
    mul_b  = {2'b00, pre_gain_r};
    if (state_r == ST_MUL1) begin
      mul_en = 1'b1;
    end else if (state_r == ST_MUL2) begin
      mul_en = 1'b1;
      mul_a  = v_r;
      mul_b  = {2'b00, gain_r};
    end
  end

  jac_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // deadzone and offset on the Q.12 pre-gain product
  logic signed [32:0]        p;
  logic [32:0]               pm;
  logic [32:0]               dz;
  logic signed [MUL_A_W-1:0] off_q;

  assign p     = prod[32:0];
  assign pm    = p[32] ? (33'd0 - $unsigned(p)) : $unsigned(p);
  assign dz    = {5'd0, deadzone_r, 12'd0};
  assign off_q = {{(MUL_A_W-28){offset_r[15]}}, offset_r, 12'd0};

  // round half away from zero: add 2^19, or 2^19-1 for negatives, then floor
  logic [PROD_W-1:0] rnd_add;
  logic [PROD_W-1:0] rnd_sum;

  assign rnd_add = prod[PROD_W-1] ? PROD_W'(20'h7FFFF) : PROD_W'(20'h80000);
  assign rnd_sum = $unsigned(prod) + rnd_add;

  // button scan, one table entry a cycle
  logic [2:0]               cnt_eff;
  logic [TBL_N-1:0]         inuse;
  logic [32:0]              vm;
  logic signed [THR_W-1:0]  t_cur;
  logic [THR_W:0]           tm;
  logic                     hit;
  logic [BUTTON_SLOTS+TBL_N-1:0] held_pad;
  logic [TBL_N-1:0]         held_tbl;

  assign cnt_eff  = (btn_count_r > 3'(USE_MAX)) ? 3'(USE_MAX) : btn_count_r;
  assign vm       = val_r[31] ? (33'd0 - {1'b1, val_r}) : {1'b0, val_r};
  assign t_cur    = thr_a[idx_r[TBL_IW-1:0]];
  assign tm       = t_cur[THR_W-1] ? (17'd0 - {1'b1, t_cur}) : {1'b0, t_cur};
  assign hit      = (val_r[31] == t_cur[THR_W-1]) && (vm >= {16'd0, tm});
  assign held_pad = {{TBL_N{1'b0}}, held_r};
  assign held_tbl = held_pad[TBL_N-1:0];

  always_comb begin
    for (int i = 0; i < TBL_N; i++) begin
      inuse[i] = (3'(i) < cnt_eff);
    end
  end

  // lowest pending release
  logic [TBL_IW-1:0] rel_j;
  logic [TBL_N-1:0]  rel_oh;

  always_comb begin
    rel_j = '0;
    for (int i = TBL_N - 1; i >= 0; i--) begin
      if (rel_r[i]) begin
        rel_j = TBL_IW'(i);
      end
    end
    rel_oh = TBL_N'(1) << rel_j;
  end

  // output beat assembly
  logic              ld;
  logic [1:0]        ld_kind;
  logic [1:0]        ld_comp;
  logic signed [31:0] ld_delta;
  logic [KEY_W-1:0]  ld_key;
  logic              ld_down;
  logic              ld_last;

  // scan finish
  logic                   fin;
  logic                   fin_vld;
  logic [TBL_N-1:0]       fin_oh;
  logic [TBL_N-1:0]       fin_rel;
  logic                   fin_press;
  logic [BUTTON_SLOTS+TBL_N-1:0] rel_pad;
  logic [BUTTON_SLOTS+TBL_N-1:0] prs_pad;

  always_comb begin
    state_nxt      = state_r;
    v_nxt          = v_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    held_nxt       = held_r;
    rel_nxt        = rel_r;
    press_pend_nxt = press_pend_r;
    press_idx_nxt  = press_idx_r;
    dlt_pend_nxt   = dlt_pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ld             = 1'b0;
    ld_kind        = EV_KEY;
    ld_comp        = 2'd0;
    ld_delta       = '0;
    ld_key         = '0;
    ld_down        = 1'b0;
    ld_last        = 1'b0;
    fin            = 1'b0;
    fin_vld        = 1'b0;
    fin_oh         = '0;
    fin_rel        = '0;
    fin_press      = 1'b0;
    rel_pad        = '0;
    prs_pad        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_ADJ;
      ST_ADJ: begin
        v_nxt     = (pm < dz) ? '0 : ({p[32], p} + off_q);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: state_nxt = ST_RND;
      ST_RND: begin
        val_nxt = rnd_sum[PROD_W-1:20];
        idx_nxt = '0;
        unique case (mode)
          MODE_POS, MODE_ANG: begin
            dlt_pend_nxt = (sample_r != 16'sd0);
            state_nxt    = (sample_r != 16'sd0) ? ST_EMIT : ST_IDLE;
          end
          MODE_BTN:  state_nxt = ST_SCAN;
          MODE_NONE: state_nxt = ST_IDLE;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (idx_r >= cnt_eff) begin
          fin = 1'b1;
        end else if (hit) begin
          fin     = 1'b1;
          fin_vld = 1'b1;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
        if (fin) begin
          fin_oh    = fin_vld ? (TBL_N'(1) << idx_r[TBL_IW-1:0]) : '0;
          fin_rel   = held_tbl & inuse & ~fin_oh;
          fin_press = fin_vld && !held_tbl[idx_r[TBL_IW-1:0]];
          rel_pad   = {{BUTTON_SLOTS{1'b0}}, fin_rel};
          prs_pad   = {{BUTTON_SLOTS{1'b0}}, fin_oh};
          held_nxt  = (held_r & ~rel_pad[BUTTON_SLOTS-1:0]) | prs_pad[BUTTON_SLOTS-1:0];
          rel_nxt        = fin_rel;
          press_pend_nxt = fin_press;
          press_idx_nxt  = idx_r[TBL_IW-1:0];
          state_nxt      = ((fin_rel != '0) || fin_press) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          priority if (dlt_pend_r) begin
            ld           = 1'b1;
            ld_last      = 1'b1;
            dlt_pend_nxt = 1'b0;
            if (mode == MODE_ANG) begin
              ld_kind  = EV_ANG;
              ld_comp  = alt ? 2'd1 : 2'd0;
              ld_delta = (val_r == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -val_r;
            end else begin
              ld_kind  = EV_POS;
              ld_comp  = alt ? 2'd2 : 2'd0;
              ld_delta = val_r;
            end
          end else if (rel_r != '0) begin
            ld      = 1'b1;
            ld_key  = keys_a[rel_j];
            rel_nxt = rel_r & ~rel_oh;
            ld_last = (rel_nxt == '0) && !press_pend_r;
          end else if (press_pend_r) begin
            ld             = 1'b1;
            ld_key         = keys_a[press_idx_r];
            ld_down        = 1'b1;
            ld_last        = 1'b1;
            press_pend_nxt = 1'b0;
          end else begin
            ld_last = 1'b1;
          end
          if (ld) begin
            out_valid_nxt = 1'b1;
          end
          if (ld_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
      dlt_pend_r   <= 1'b0;
      press_pend_r <= 1'b0;
      rel_r        <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
      dlt_pend_r   <= dlt_pend_nxt;
      press_pend_r <= press_pend_nxt;
      rel_r        <= rel_nxt;
      idx_r        <= idx_nxt;
    end
  end

  logic [1:0]         kind_r;
  logic [1:0]         comp_r;
  logic signed [31:0] delta_r;
  logic [KEY_W-1:0]   key_r;
  logic               down_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_axis_sample;
    end
    v_r         <= v_nxt;
    val_r       <= val_nxt;
    press_idx_r <= press_idx_nxt;
    if (ld) begin
      kind_r  <= ld_kind;
      comp_r  <= ld_comp;
      delta_r <= ld_delta;
      key_r   <= ld_key;
      down_r  <= ld_down;
      last_r  <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_component  = comp_r;
  assign out_delta      = delta_r;
  assign out_key_code   = key_r;
  assign out_key_down   = down_r;
  assign out_last_event = last_r;

`ifndef ASSERT_OFF
  // held flags only move when a button scan finishes
  a_held_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_r) |-> $past(state_r) == ST_SCAN)
    else $error("held flags changed outside a scan");

  // a press is always the final event of its sample
  a_press_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_KEY && out_key_down |-> out_last_event)
    else $error("press event not marked last");

  // delta beats stand alone
  a_delta_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_KEY |-> out_last_event)
    else $error("delta event not marked last");

  // no new sample is taken while events are still being generated
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> in_stall)
    else $error("input open during event generation");
`endif

endmodule

@@ src/jac_mul.sv @@
// jac_mul: shared signed multiplier with a registered product
// depends on jac_pkg for the operand widths

module jac_mul
  import jac_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [MUL_A_W-1:0]  op_a,
  input  logic signed [MUL_B_W-1:0]  op_b,
  output logic signed [PROD_W-1:0]   prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule
